// ----- rtl/core/dvsp_pkg.sv -----
// ============================================================================
// dvsp_pkg: shared types and constants of the drum voice sample player
// Field types of the request and result items, item kinds, register indexes,
// and the control bundle that travels down the voice chain.
// ============================================================================
package dvsp_pkg;

  // Defaults of the top-level parameters
  localparam int DEF_NUM_VOICES  = 4;
  localparam int DEF_MAX_LEN     = 16384;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed widths and counts
  localparam int NUM_LEN_REGS  = 4;
  localparam int NUM_CLASSES   = 12;   // notes wrap to voices modulo an octave
  localparam int CLASS_BITS    = 4;
  localparam int VOL_BITS      = 17;   // Q1.16 volume
  localparam int MIX_BITS      = 24;
  localparam int LEN_BITS      = 15;
  localparam int MASK_BITS     = 4;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  typedef logic        [1:0]              req_type_t;
  typedef logic        [6:0]              note_t;
  typedef logic        [15:0]             velocity_t;
  typedef logic        [1:0]              voice_sel_t;
  typedef logic        [13:0]             load_addr_t;
  typedef logic signed [15:0]             load_word_t;
  typedef logic signed [MIX_BITS-1:0]     mix_t;
  typedef logic        [MASK_BITS-1:0]    mask_t;
  typedef logic        [LEN_BITS-1:0]     len_t;
  typedef logic        [VOL_BITS-1:0]     vol_t;
  typedef logic        [CLASS_BITS-1:0]   vclass_t;

  localparam vol_t VOL_MAX = '1;

  // Item kinds
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_NOTE = 2'd1,
    REQ_TICK = 2'd2
  } req_kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LENGTH_VOICE0 = 2'd0,
    REG_LENGTH_VOICE1 = 2'd1,
    REG_LENGTH_VOICE2 = 2'd2,
    REG_LENGTH_VOICE3 = 2'd3
  } reg_idx_t;

  // Control bundle handed from stage to stage along the chain
  typedef struct packed {
    logic       valid;
    req_kind_t  kind;
    vclass_t    vclass;
    vol_t       vol;
    voice_sel_t load_voice;
    load_addr_t load_addr;
    mask_t      mask;
  } ctl_t;

endpackage

// ----- rtl/core/dvsp_req_if.sv -----
// ============================================================================
// dvsp_req_if: request channel of the drum voice sample player
// Valid/ready channel carrying load, note-on and tick items.
// ============================================================================
interface dvsp_req_if;
  import dvsp_pkg::*;

  logic       valid;
  logic       ready;
  req_type_t  req_type;
  note_t      note;
  velocity_t  velocity;
  voice_sel_t load_voice;
  load_addr_t load_address;
  load_word_t load_word;
  mix_t       mix_in;

  modport source (
    output valid, req_type, note, velocity, load_voice, load_address, load_word, mix_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, note, velocity, load_voice, load_address, load_word, mix_in,
    output ready
  );
endinterface

// ----- rtl/core/dvsp_res_if.sv -----
// ============================================================================
// dvsp_res_if: result channel of the drum voice sample player
// Valid/ready channel carrying one mixed output sample per tick.
// ============================================================================
interface dvsp_res_if;
  import dvsp_pkg::*;

  logic  valid;
  logic  ready;
  mix_t  mix_out;
  mask_t playing_mask;

  modport source (
    output valid, mix_out, playing_mask,
    input  ready
  );

  modport sink (
    input  valid, mix_out, playing_mask,
    output ready
  );
endinterface

// ----- rtl/core/dvsp_ram.sv -----
// ============================================================================
// dvsp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered under read enable.
// ============================================================================
module dvsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/core/dvsp_vol.sv -----
// ============================================================================
// dvsp_vol: front end of the voice chain
// Registers the request item, maps the note to its class, scales the mix
// and turns velocity into a Q1.16 volume, 2 * velocity^2, rounded.
// ============================================================================
module dvsp_vol #(
  parameter int SAMPLE_BITS = dvsp_pkg::DEF_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         accept,
  dvsp_req_if.sink                     req,
  output dvsp_pkg::ctl_t               ctl_out,
  output logic signed [SAMPLE_BITS-1:0] word_out,
  output logic signed [SAMPLE_BITS+25:0] acc_out
);
  import dvsp_pkg::*;

  localparam int AccW     = SAMPLE_BITS + 26;
  localparam int WordBits = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int ProdW    = 50;
  localparam int NumW     = 51;
  localparam int QW       = 18;
  // 65535^2 divides the scaled square; reciprocal for the estimate
  localparam longint unsigned VolDen   = 64'd4294836225;
  localparam longint unsigned VolHalf  = VolDen / 2;
  localparam longint unsigned VolRecip = (64'd1 << 49) / VolDen;
  // note / 12 for notes below 128: (note * 43) >> 9
  localparam int ClassRecip = 43;
  localparam int ClassShift = 9;

  logic                    s1_ok;
  ctl_t                    s1_ctl, s2_ctl, s3_ctl;
  logic signed [SAMPLE_BITS-1:0] s1_word, s2_word, s3_word;
  logic signed [AccW-1:0]  s1_acc, s2_acc, s3_acc;
  logic [31:0]             s1_x, s2_x;
  logic [ProdW-1:0]        s2_p;
  logic [QW-1:0]           s3_q0;
  logic [NumW-1:0]         s3_t, s3_n;
  logic [12:0]             cls_prod;
  logic [6:0]              cls_quot;
  ctl_t                    s1_ctl_next;
  logic [NumW-1:0]         rem;
  logic [QW-1:0]           quot;
  vol_t                    vol_next;
  ctl_t                    ctl_out_next;

  // Decode of the incoming item
  always_comb begin
    s1_ok    = (req.req_type == REQ_LOAD) || (req.req_type == REQ_NOTE) ||
               (req.req_type == REQ_TICK);
    cls_prod = 13'(req.note) * 13'(ClassRecip);
    cls_quot = 7'(cls_prod >> ClassShift);
    s1_ctl_next            = '0;
    s1_ctl_next.valid      = accept && s1_ok;
    s1_ctl_next.kind       = req_kind_t'(req.req_type);
    s1_ctl_next.vclass     = CLASS_BITS'(req.note - cls_quot * 7'(NUM_CLASSES));
    s1_ctl_next.load_voice = req.load_voice;
    s1_ctl_next.load_addr  = req.load_address;
  end

  // Stage 1: square of velocity, sample word and scaled mix
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else if (en) begin
      s1_ctl  <= s1_ctl_next;
      s1_word <= SAMPLE_BITS'($signed(req.load_word[WordBits-1:0]));
      s1_acc  <= AccW'(req.mix_in) <<< SAMPLE_BITS;
      s1_x    <= 32'(req.velocity) * 32'(req.velocity);
    end
  end

  // Stage 2: quotient estimate by reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else if (en) begin
      s2_ctl  <= s1_ctl;
      s2_word <= s1_word;
      s2_acc  <= s1_acc;
      s2_x    <= s1_x;
      s2_p    <= ProdW'(s1_x) * ProdW'(VolRecip);
    end
  end

  // Stage 3: back-multiply the estimate, form the rounded numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl.valid <= 1'b0;
    end else if (en) begin
      s3_ctl  <= s2_ctl;
      s3_word <= s2_word;
      s3_acc  <= s2_acc;
      s3_q0   <= QW'(s2_p >> 32);
      s3_t    <= NumW'(s2_p >> 32) * NumW'(VolDen);
      s3_n    <= (NumW'(s2_x) << 17) + NumW'(VolHalf);
    end
  end

  // Correction: estimate is low by at most two
  always_comb begin
    rem  = s3_n - s3_t;
    quot = s3_q0 + QW'(rem >= NumW'(VolDen)) + QW'(rem >= NumW'(2 * VolDen));
    vol_next = (quot > QW'(VOL_MAX)) ? VOL_MAX : VOL_BITS'(quot);
    ctl_out_next     = s3_ctl;
    ctl_out_next.vol = vol_next;
  end

  // Stage 4: hand over to the first voice cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out     <= ctl_out_next;
      word_out    <= s3_word;
      acc_out     <= s3_acc;
    end
  end
endmodule

// ----- rtl/core/dvsp_cell.sv -----
// ============================================================================
// dvsp_cell: one voice of the chain
// Holds the voice's cursor, run flag, volume and sample bank. Loads and
// note-ons for this voice update it; a tick adds word * volume to the mix
// handed on to the next cell.
// ============================================================================
module dvsp_cell #(
  parameter int VOICE       = 0,
  parameter int NUM_VOICES  = dvsp_pkg::DEF_NUM_VOICES,
  parameter int MAX_LEN     = dvsp_pkg::DEF_MAX_LEN,
  parameter int SAMPLE_BITS = dvsp_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [$clog2(MAX_LEN+1)-1:0]   len,
  input  dvsp_pkg::ctl_t                 ctl_in,
  input  logic signed [SAMPLE_BITS-1:0]  word_in,
  input  logic signed [SAMPLE_BITS+25:0] acc_in,
  output dvsp_pkg::ctl_t                 ctl_out,
  output logic signed [SAMPLE_BITS-1:0]  word_out,
  output logic signed [SAMPLE_BITS+25:0] acc_out
);
  import dvsp_pkg::*;

  localparam int CurW  = $clog2(MAX_LEN + 1);
  localparam int AddrW = $clog2(MAX_LEN);
  localparam int AccW  = SAMPLE_BITS + 26;
  localparam int ProdW = SAMPLE_BITS + VOL_BITS + 1;

  // Voice state
  logic [CurW-1:0] cursor;
  logic            playing;
  vol_t            volume;

  logic            hit_class, is_note, is_load, is_tick, play_now, stop_now;
  ctl_t            ctl_a;
  logic [SAMPLE_BITS-1:0] rd_word;

  ctl_t                          ctl_b, ctl_c;
  logic signed [SAMPLE_BITS-1:0] word_b, word_c;
  logic signed [AccW-1:0]        acc_b, acc_c;
  logic                          add_b;
  vol_t                          vol_b;
  logic signed [ProdW-1:0]       prod_c;

  // Which items concern this voice
  always_comb begin
    hit_class = 1'b0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if ((VOICE + k * NUM_VOICES < NUM_CLASSES) &&
          (ctl_in.vclass == CLASS_BITS'(VOICE + k * NUM_VOICES))) begin
        hit_class = 1'b1;
      end
    end
    is_note  = ctl_in.valid && (ctl_in.kind == REQ_NOTE) && hit_class;
    is_load  = ctl_in.valid && (ctl_in.kind == REQ_LOAD) &&
               (32'(ctl_in.load_voice) == VOICE) &&
               (32'(ctl_in.load_addr) < 32'(MAX_LEN));
    is_tick  = ctl_in.valid && (ctl_in.kind == REQ_TICK);
    play_now = is_tick && playing && (cursor < len);
    stop_now = is_tick && playing && !(cursor < len);
    ctl_a = ctl_in;
    for (int b = 0; b < MASK_BITS; b++) begin
      if (b == VOICE) begin
        ctl_a.mask[b] = play_now;
      end
    end
  end

  // Cursor, run flag and volume
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '0;
      playing <= 1'b0;
      volume  <= '0;
    end else if (en) begin
      if (is_note) begin
        cursor  <= '0;
        playing <= 1'b1;
        volume  <= ctl_in.vol;
      end else if (play_now) begin
        cursor <= cursor + CurW'(1);
      end else if (stop_now) begin
        cursor  <= '0;
        playing <= 1'b0;
      end
    end
  end

  // Sample bank of this voice
  dvsp_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_LEN)
  ) u_bank (
    .clk  (clk),
    .we   (en && is_load),
    .waddr(AddrW'(ctl_in.load_addr)),
    .wdata(word_in),
    .re   (en),
    .raddr(cursor[AddrW-1:0]),
    .rdata(rd_word)
  );

  // Stage B: wait for the bank read
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b.valid <= 1'b0;
    end else if (en) begin
      ctl_b  <= ctl_a;
      word_b <= word_in;
      acc_b  <= acc_in;
      add_b  <= play_now;
      vol_b  <= volume;
    end
  end

  // Stage C: word times volume
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c.valid <= 1'b0;
    end else if (en) begin
      ctl_c  <= ctl_b;
      word_c <= word_b;
      acc_c  <= acc_b;
      prod_c <= add_b ? ProdW'($signed(rd_word)) * ProdW'($signed({1'b0, vol_b}))
                      : '0;
    end
  end

  // Output: accumulate into the mix
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out  <= ctl_c;
      word_out <= word_c;
      acc_out  <= acc_c + AccW'(prod_c);
    end
  end
endmodule

// ----- rtl/core/drum_voice_sample_player.sv -----
// ============================================================================
// drum_voice_sample_player: one-shot drum sample player with mix bus
// Per-voice sample banks, note-on triggering with squared-velocity volume,
// and a saturated 24-bit mix output per tick.
// ============================================================================
// Takes one item every clock cycle unless the pipeline stalls. Each item enters a
// four-stage front end (volume from velocity) and then walks a chain of NUM_VOICES
// voice cells, three stages per cell, and a tick's result then passes the output
// register; loads and note-ons give no result. Every cell owns its
// voice's state and a MAX_LEN-word bank with one write and one registered read
// port, so all voices are read in the same tick. Banks are not cleared: a
// sample word must be loaded before a voice plays it. Voice v answers note
// numbers whose value modulo 12, then modulo NUM_VOICES, equals v. The
// pipeline stalls only when a tick is ready to leave and the output register
// still holds an untaken result. Lengths are set over the APB port at 4*i.
module drum_voice_sample_player #(
  parameter int NUM_VOICES  = dvsp_pkg::DEF_NUM_VOICES,
  parameter int MAX_LEN     = dvsp_pkg::DEF_MAX_LEN,
  parameter int SAMPLE_BITS = dvsp_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  dvsp_req_if.sink                           req,
  dvsp_res_if.source                         res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dvsp_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [dvsp_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [dvsp_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import dvsp_pkg::*;

  localparam int CurW = $clog2(MAX_LEN + 1);
  localparam int AccW = SAMPLE_BITS + 26;
  localparam int ShW  = AccW - SAMPLE_BITS;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (SAMPLE_BITS - 1);
  localparam logic signed [ShW-1:0]  MixHi = ShW'((1 << (MIX_BITS - 1)) - 1);
  localparam logic signed [ShW-1:0]  MixLo = ShW'(-(1 << (MIX_BITS - 1)));

  len_t                          len_reg [NUM_LEN_REGS];
  logic [CurW-1:0]               voice_len [NUM_VOICES];
  ctl_t                          chain_ctl  [NUM_VOICES+1];
  logic signed [SAMPLE_BITS-1:0] chain_word [NUM_VOICES+1];
  logic signed [AccW-1:0]        chain_acc  [NUM_VOICES+1];
  logic                          adv, last_tick, cfg_wr;
  reg_idx_t                      reg_idx;
  logic signed [AccW-1:0]        rounded;
  logic signed [ShW-1:0]         scaled;
  mix_t                          mix_next;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEN_REGS; i++) begin
        len_reg[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LENGTH_VOICE0: len_reg[0] <= pwdata[LEN_BITS-1:0];
        REG_LENGTH_VOICE1: len_reg[1] <= pwdata[LEN_BITS-1:0];
        REG_LENGTH_VOICE2: len_reg[2] <= pwdata[LEN_BITS-1:0];
        REG_LENGTH_VOICE3: len_reg[3] <= pwdata[LEN_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LENGTH_VOICE0: prdata = APB_DATA_BITS'(len_reg[0]);
      REG_LENGTH_VOICE1: prdata = APB_DATA_BITS'(len_reg[1]);
      REG_LENGTH_VOICE2: prdata = APB_DATA_BITS'(len_reg[2]);
      REG_LENGTH_VOICE3: prdata = APB_DATA_BITS'(len_reg[3]);
    endcase
  end

  // Effective length per voice, capped at the bank size
  for (genvar gv = 0; gv < NUM_VOICES; gv++) begin : g_len
    if (gv < NUM_LEN_REGS) begin : g_reg
      assign voice_len[gv] = (32'(len_reg[gv]) > 32'(MAX_LEN)) ? CurW'(MAX_LEN)
                                                                : CurW'(len_reg[gv]);
    end else begin : g_none
      assign voice_len[gv] = '0;
    end
  end

  // Global advance: hold only when a result would hit a full output register
  assign last_tick = chain_ctl[NUM_VOICES].valid && (chain_ctl[NUM_VOICES].kind == REQ_TICK);
  assign adv       = !(last_tick && res.valid && !res.ready);
  assign req.ready = adv;

  dvsp_vol #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_vol (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .accept  (req.valid && adv),
    .req     (req),
    .ctl_out (chain_ctl[0]),
    .word_out(chain_word[0]),
    .acc_out (chain_acc[0])
  );

  // Chain of voice cells
  for (genvar gv = 0; gv < NUM_VOICES; gv++) begin : g_cell
    dvsp_cell #(
      .VOICE      (gv),
      .NUM_VOICES (NUM_VOICES),
      .MAX_LEN    (MAX_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .len     (voice_len[gv]),
      .ctl_in  (chain_ctl[gv]),
      .word_in (chain_word[gv]),
      .acc_in  (chain_acc[gv]),
      .ctl_out (chain_ctl[gv+1]),
      .word_out(chain_word[gv+1]),
      .acc_out (chain_acc[gv+1])
    );
  end

  // Round half up, drop the fraction, saturate to the mix range
  always_comb begin
    rounded = chain_acc[NUM_VOICES] + RoundHalf;
    scaled  = rounded[AccW-1:SAMPLE_BITS];
    if (scaled > MixHi) begin
      mix_next = MIX_BITS'(MixHi);
    end else if (scaled < MixLo) begin
      mix_next = MIX_BITS'(MixLo);
    end else begin
      mix_next = MIX_BITS'(scaled);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      if (adv && last_tick) begin
        res.valid        <= 1'b1;
        res.mix_out      <= mix_next;
        res.playing_mask <= chain_ctl[NUM_VOICES].mask;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Checks
  a_stall_reaches_input: assert property (@(posedge clk) disable iff (rst)
    (last_tick && res.valid && !res.ready) |-> !req.ready)
    else $error("input taken while a result is blocked");

  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(chain_ctl[NUM_VOICES]) && $stable(chain_acc[NUM_VOICES]))
    else $error("chain moved during a stall");

  a_mask_in_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ((32'(res.playing_mask) >> NUM_VOICES) == 32'd0))
    else $error("playing mask shows a voice that does not exist");
endmodule

// ----- bench/dvsp_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// dvsp_checker: result checker of the drum voice sample player
// Watches the request channel and the APB write port, keeps its own copy of
// the sample banks and voice state, predicts the mixed sample of every tick
// and compares each result item field by field with the oldest prediction.
// ============================================================================
module dvsp_checker (
  input  logic                               clk,
  input  logic                               rst,
  dvsp_req_if                                req_mon,
  dvsp_res_if                                res_mon,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [dvsp_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [dvsp_pkg::APB_DATA_BITS-1:0] pwdata,
  output int                                 mismatch_count,
  output int                                 mix_backlog
);
  import dvsp_pkg::*;

  localparam int VOICES = DEF_NUM_VOICES;
  localparam int BANK_WORDS = DEF_MAX_LEN;
  localparam longint unsigned VEL_FULL_SQ = 64'd65535 * 64'd65535;
  localparam longint MIX_HI = 64'sd8388607;
  localparam longint MIX_LO = -64'sd8388608;

  typedef struct packed {
    mix_t  mix;
    mask_t mask;
  } mix_result_t;

  // Predicted mix samples, oldest first
  mix_result_t expected_mix[$];

  // Mirror of the block state
  load_word_t  sample_bank [VOICES][BANK_WORDS];
  int unsigned play_cursor [VOICES];
  logic        voice_active[VOICES];
  vol_t        voice_gain  [VOICES];
  len_t        length_reg  [NUM_LEN_REGS];

  int mismatches = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : predict_and_compare
    longint           acc;
    longint           rounded;
    longint unsigned  vel_sq;
    longint unsigned  gain_q;
    int unsigned      len;
    int unsigned      v;
    mask_t            mask;
    mix_result_t      want;
    if (rst) begin
      for (v = 0; v < VOICES; v++) begin
        play_cursor[v]  = 0;
        voice_active[v] = 1'b0;
        voice_gain[v]   = '0;
      end
      for (v = 0; v < NUM_LEN_REGS; v++) length_reg[v] = '0;
      expected_mix.delete();
    end else begin
      // Length register writes
      if (psel && penable && pwrite && pready)
        length_reg[paddr[APB_ADDR_BITS-1:2]] = len_t'(pwdata[LEN_BITS-1:0]);

      // Result items against the oldest prediction
      if (res_mon.valid && res_mon.ready) begin
        if (expected_mix.size() == 0) begin
          report_mismatch($sformatf("result with none pending: mix %0d mask %b",
                                    res_mon.mix_out, res_mon.playing_mask));
        end else begin
          want = expected_mix.pop_front();
          if (res_mon.mix_out !== want.mix)
            report_mismatch($sformatf("mix_out %0d, predicted %0d",
                                      res_mon.mix_out, want.mix));
          if (res_mon.playing_mask !== want.mask)
            report_mismatch($sformatf("playing_mask %b, predicted %b",
                                      res_mon.playing_mask, want.mask));
        end
      end

      // Request items update the mirror
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.req_type)
          REQ_LOAD: begin
            if (int'(req_mon.load_voice) < VOICES && int'(req_mon.load_address) < BANK_WORDS)
              sample_bank[req_mon.load_voice][req_mon.load_address] = req_mon.load_word;
          end
          REQ_NOTE: begin
            // gain = 2 * velocity^2 in Q1.16, rounded half up, clipped
            vel_sq = 64'(req_mon.velocity) * 64'(req_mon.velocity);
            gain_q = (vel_sq * 64'd131072 + VEL_FULL_SQ / 2) / VEL_FULL_SQ;
            v = (int'(req_mon.note) % NUM_CLASSES) % VOICES;
            play_cursor[v]  = 0;
            voice_active[v] = 1'b1;
            voice_gain[v]   = (gain_q > 64'(VOL_MAX)) ? VOL_MAX : vol_t'(gain_q);
          end
          REQ_TICK: begin
            acc = longint'(req_mon.mix_in) * (64'sd1 << DEF_SAMPLE_BITS);
            for (v = 0; v < VOICES; v++) begin
              len = (int'(length_reg[v]) > BANK_WORDS) ? BANK_WORDS : int'(length_reg[v]);
              if (voice_active[v]) begin
                if (play_cursor[v] >= len) begin
                  // ran past its last word: stops and adds nothing
                  voice_active[v] = 1'b0;
                  play_cursor[v]  = 0;
                end else begin
                  acc += longint'(sample_bank[v][play_cursor[v]]) *
                         longint'({1'b0, voice_gain[v]});
                  play_cursor[v]++;
                end
              end
            end
            mask = '0;
            for (v = 0; v < VOICES && v < MASK_BITS; v++)
              mask[v] = voice_active[v];
            rounded = (acc + (64'sd1 << (DEF_SAMPLE_BITS - 1))) >>> DEF_SAMPLE_BITS;
            if (rounded > MIX_HI) rounded = MIX_HI;
            if (rounded < MIX_LO) rounded = MIX_LO;
            want.mix  = mix_t'(rounded);
            want.mask = mask;
            expected_mix.push_back(want);
          end
          default: begin
            // unused request code: no effect
          end
        endcase
      end
    end
    mismatch_count <= mismatches;
    mix_backlog    <= expected_mix.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the drum voice sample player
// Drives load, note-on and tick items with random gaps and result stalls,
// sets the voice lengths over APB between phases, and gives the verdict from
// the checker's mismatch count once every predicted mix sample has arrived.
// ============================================================================
module tb_top;
  import dvsp_pkg::*;

  localparam int          VOICES       = DEF_NUM_VOICES;
  localparam int          BANK_WORDS   = DEF_MAX_LEN;
  localparam int          DRAIN_CYCLES = 3 * VOICES + 5 + 30;
  localparam req_type_t   REQ_UNUSED   = 2'd3;
  localparam mix_t        MIX_TOP      = 24'sh7FFFFF;
  localparam mix_t        MIX_BOTTOM   = 24'sh800000;

  logic clk;
  logic rst;

  // APB port
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  dvsp_req_if req_ch();
  dvsp_res_if res_ch();

  int mismatch_count;
  int mix_backlog;

  // Pacing: 0 turns idling off, else one chance in N per item or cycle
  int unsigned send_odds = 0;
  int unsigned recv_odds = 0;

  // What the stimulus knows of the voices, so no unloaded word is ever played
  int unsigned play_pos   [VOICES];
  bit          voice_on   [VOICES];
  int unsigned voice_len  [VOICES];
  bit          word_loaded[VOICES][BANK_WORDS];

  drum_voice_sample_player dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dvsp_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_mon        (req_ch),
    .res_mon        (res_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .mix_backlog    (mix_backlog)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: ready drops in bursts
  initial begin : sink_pacing
    int unsigned hold;
    hold = 0;
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        if (hold == 0) res_ch.ready <= 1'b1;
      end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
        hold = $urandom_range(1, 15);
        res_ch.ready <= 1'b0;
      end
    end
  end

  function automatic load_word_t pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return load_word_t'($urandom);
  endfunction

  // One item: optional gap, then hold valid until taken
  task automatic send_item(req_type_t kind, note_t n, velocity_t vel, voice_sel_t lv,
                           load_addr_t la, load_word_t w, mix_t m);
    if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.note         <= n;
    req_ch.velocity     <= vel;
    req_ch.load_voice   <= lv;
    req_ch.load_address <= la;
    req_ch.load_word    <= w;
    req_ch.mix_in       <= m;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_load(voice_sel_t lv, load_addr_t la, load_word_t w);
    word_loaded[lv][la] = 1'b1;
    send_item(REQ_LOAD, note_t'($urandom), velocity_t'($urandom), lv, la, w,
              mix_t'($urandom));
  endtask

  task automatic send_note(note_t n, velocity_t vel);
    int unsigned v;
    v = (int'(n) % NUM_CLASSES) % VOICES;
    play_pos[v] = 0;
    voice_on[v] = 1'b1;
    send_item(REQ_NOTE, n, vel, voice_sel_t'($urandom), load_addr_t'($urandom),
              load_word_t'($urandom), mix_t'($urandom));
  endtask

  task automatic send_tick(mix_t m);
    int unsigned v;
    // fill any word a playing voice is about to read
    for (v = 0; v < VOICES; v++)
      if (voice_on[v] && play_pos[v] < voice_len[v] && !word_loaded[v][play_pos[v]])
        send_load(voice_sel_t'(v), load_addr_t'(play_pos[v]), pick_word());
    send_item(REQ_TICK, note_t'($urandom), velocity_t'($urandom), voice_sel_t'($urandom),
              load_addr_t'($urandom), load_word_t'($urandom), m);
    for (v = 0; v < VOICES; v++)
      if (voice_on[v]) begin
        if (play_pos[v] >= voice_len[v]) begin
          voice_on[v] = 1'b0;
          play_pos[v] = 0;
        end else begin
          play_pos[v]++;
        end
      end
  endtask

  task automatic send_junk();
    send_item(REQ_UNUSED, note_t'($urandom), velocity_t'($urandom), voice_sel_t'($urandom),
              load_addr_t'($urandom), load_word_t'($urandom), mix_t'($urandom));
  endtask

  // Wait until every predicted sample is back and the pipeline has emptied
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (mix_backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup and access cycle; psel stays up between back-to-back writes
  task automatic write_length(reg_idx_t idx, int unsigned value);
    logic [APB_DATA_BITS-1:0] upper;
    upper = ($urandom_range(0, 1) == 0) ? '0 : ($urandom & 32'hFFFF_8000);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(4 * int'(idx));
    pwdata  <= upper | APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    voice_len[idx] = (value > BANK_WORDS) ? BANK_WORDS : value;
  endtask

  task automatic set_lengths(int unsigned l0, int unsigned l1, int unsigned l2,
                             int unsigned l3);
    int unsigned lens[4];
    int unsigned i;
    lens = '{l0, l1, l2, l3};
    settle();
    for (i = 0; i < 4; i++) write_length(reg_idx_t'(i), lens[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random mix of loads, note-ons and ticks; unused codes do not count
  task automatic random_items(int unsigned count, int unsigned span);
    int unsigned done;
    int unsigned pick;
    velocity_t   vel;
    mix_t        m;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_junk();
      end else begin
        done++;
        if (pick < 28) begin
          send_load(voice_sel_t'($urandom),
                    ($urandom_range(0, 7) == 0) ? load_addr_t'($urandom)
                                                : load_addr_t'($urandom_range(0, span)),
                    pick_word());
        end else if (pick < 42) begin
          case ($urandom_range(0, 7))
            0:       vel = 16'd0;
            1:       vel = 16'hFFFF;
            default: vel = velocity_t'($urandom);
          endcase
          send_note(note_t'($urandom), vel);
        end else begin
          case ($urandom_range(0, 9))
            0:       m = MIX_TOP;
            1:       m = MIX_BOTTOM;
            2, 3, 4: m = mix_t'($urandom);
            default: m = mix_t'(int'($urandom_range(0, 65535)) - 32768);
          endcase
          send_tick(m);
        end
      end
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_LOAD;
    req_ch.note         <= '0;
    req_ch.velocity     <= '0;
    req_ch.load_voice   <= '0;
    req_ch.load_address <= '0;
    req_ch.load_word    <= '0;
    req_ch.mix_in       <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    for (int v = 0; v < VOICES; v++) begin
      play_pos[v]  = 0;
      voice_on[v]  = 1'b0;
      voice_len[v] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lengths at reset: mix passes through, a zero-length voice stops at once
    send_odds = 4;
    recv_odds = 4;
    send_tick(MIX_TOP);
    send_tick(MIX_BOTTOM);
    send_note(7'd0, 16'hFFFF);
    send_tick(24'sd0);
    send_junk();

    // Extremes of words, gains and lengths; length above the store on voice 1
    set_lengths(2, 32767, 1, 16384);
    send_load(2'd0, 14'd0, 16'sh7FFF);
    send_load(2'd0, 14'd1, 16'sh8000);
    send_load(2'd1, 14'd0, 16'sh8000);
    send_load(2'd2, 14'd0, 16'sh7FFF);
    send_load(2'd3, 14'h3FFF, 16'sh5A5A);
    send_load(2'd3, 14'd0, -16'sd1);
    send_note(7'd0, 16'hFFFF);
    send_note(7'd13, 16'd0);
    send_note(7'd2, 16'd46341);
    send_note(7'd127, 16'hFFFF);
    send_tick(MIX_TOP);
    send_tick(MIX_BOTTOM);
    // voice 0 has played its last word and stops here
    send_tick(24'sd0);
    send_note(7'd12, 16'd32768);
    // retrigger of the still playing voice 3
    send_note(7'd3, 16'd1);
    send_tick(mix_t'($urandom));
    send_tick(24'sd0);

    send_odds = 6;
    recv_odds = 6;
    random_items(180, 63);

    send_odds = 3;
    recv_odds = 0;
    set_lengths($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
                $urandom_range(0, 40));
    random_items(180, 48);

    send_odds = 0;
    recv_odds = 4;
    set_lengths(0, 16384, 0, 1);
    random_items(150, 80);

    send_odds = 8;
    recv_odds = 8;
    set_lengths($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
                $urandom_range(0, 40));
    random_items(180, 48);

    send_odds = 4;
    recv_odds = 3;
    set_lengths($urandom_range(0, 64), $urandom_range(0, 8), 32767, $urandom_range(0, 64));
    random_items(180, 72);

    // Closing stretch at full rate
    send_odds = 0;
    recv_odds = 0;
    set_lengths($urandom_range(0, 24), $urandom_range(0, 24), $urandom_range(0, 24),
                $urandom_range(0, 24));
    random_items(200, 32);

    settle();
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
